>>> hw/rtl/mfd_pkg.sv
// Shared types and constants for the frame deframer.
package mfd_pkg;

    localparam int unsigned HDR_BYTES  = 8;
    localparam int unsigned HDR_W      = 8 * HDR_BYTES;
    localparam int unsigned HDR_CNT_W  = 4;
    localparam int unsigned LEN_W      = 32;
    localparam int unsigned MAX_W      = 21;

    localparam logic [HDR_CNT_W-1:0] HDR_FULL      = HDR_CNT_W'(HDR_BYTES);
    localparam logic [MAX_W-1:0]     MAX_PAYLOAD_RST = 21'd65536;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_HEADER = 2'd0;
    localparam kind_t KIND_DATA   = 2'd1;
    localparam kind_t KIND_ERROR  = 2'd2;

    typedef struct packed {
        logic             valid;
        kind_t            kind;
        logic [HDR_W-1:0] hdr;
        logic [7:0]       data;
        logic             last;
    } result_t;

endpackage

>>> hw/rtl/mfd_parser.sv
// Header collection, length check, payload count and error discard.
module mfd_parser (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_accept,
    input  logic [7:0]                 in_byte,
    input  logic                       in_chunk_end,
    input  logic [mfd_pkg::MAX_W-1:0]  max_payload,
    output mfd_pkg::result_t           res
);

    logic [mfd_pkg::HDR_W-1:0]     hdr_reg, hdr_next;
    logic [mfd_pkg::HDR_CNT_W-1:0] cnt_reg, cnt_next;
    logic [mfd_pkg::LEN_W-1:0]     left_reg, left_next;
    logic                          discard_reg, discard_next;

    logic [mfd_pkg::HDR_W-1:0]     hdr_fill;
    logic [mfd_pkg::LEN_W-1:0]     left_dec;
    logic [mfd_pkg::LEN_W-1:0]     len;
    logic [mfd_pkg::HDR_CNT_W-1:0] cnt_inc;

    always_comb begin
        hdr_fill = hdr_reg;
        hdr_fill[cnt_reg[2:0]*8 +: 8] = in_byte;
        left_dec = left_reg - 1'b1;
        len      = hdr_fill[mfd_pkg::HDR_W-1 -: mfd_pkg::LEN_W];
        cnt_inc  = cnt_reg + 1'b1;

        hdr_next     = hdr_reg;
        cnt_next     = cnt_reg;
        left_next    = left_reg;
        discard_next = discard_reg;

        res.valid = 1'b0;
        res.kind  = mfd_pkg::KIND_DATA;
        res.hdr   = hdr_reg;
        res.data  = 8'd0;
        res.last  = 1'b0;

        if (discard_reg) begin
            if (in_chunk_end) begin
                discard_next = 1'b0;
            end
        end else if (cnt_reg == mfd_pkg::HDR_FULL) begin
            res.valid = 1'b1;
            res.data  = in_byte;
            res.last  = (left_dec == '0);
            left_next = left_dec;
            if (left_dec == '0) begin
                hdr_next = '0;
                cnt_next = '0;
            end
        end else if (cnt_inc != mfd_pkg::HDR_FULL) begin
            hdr_next = hdr_fill;
            cnt_next = cnt_inc;
        end else begin
            // header complete on this byte
            res.hdr = hdr_fill;
            if (len > mfd_pkg::LEN_W'(max_payload)) begin
                res.valid    = 1'b1;
                res.kind     = mfd_pkg::KIND_ERROR;
                res.last     = 1'b1;
                hdr_next     = '0;
                cnt_next     = '0;
                left_next    = '0;
                discard_next = !in_chunk_end;
            end else if (len == '0) begin
                res.valid = 1'b1;
                res.kind  = mfd_pkg::KIND_HEADER;
                res.last  = 1'b1;
                hdr_next  = '0;
                cnt_next  = '0;
                left_next = '0;
            end else begin
                hdr_next  = hdr_fill;
                cnt_next  = cnt_inc;
                left_next = len;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_reg     <= '0;
            cnt_reg     <= '0;
            left_reg    <= '0;
            discard_reg <= 1'b0;
        end else if (in_accept) begin
            hdr_reg     <= hdr_next;
            cnt_reg     <= cnt_next;
            left_reg    <= left_next;
            discard_reg <= discard_next;
        end
    end

endmodule

>>> hw/rtl/mux_frame_deframer.sv
// Top level of the length-prefixed frame deframer.
//
// Usage:
//   s_axis carries one stream byte per transaction in tdata; tlast marks the
//   final byte of a delivered chunk. Each frame starts with an 8-byte
//   little-endian header (type, flags, 16-bit channel, 32-bit length).
//   m_axis gives at most one result per input byte: a payload byte with the
//   header fields (tuser data), a single result for a zero-length frame
//   (tuser header), or an oversize error (tuser error); unless its header byte
//   ends a chunk, bytes after it are dropped up to and including the next chunk
//   end. tlast marks the final result of a frame and every error.
//   cfg_we/cfg_wdata write max_payload; write it only while the block is idle.
// Timing:
//   One byte accepted per cycle while m_axis takes results. A result is visible
//   on m_axis in the cycle after the byte that causes it; the path is a single
//   pass through the parser into the output register.
// Reset and stall:
//   Reset clears the header, counters and discard state, empties the output
//   register and sets max_payload to 65536. While a held result is not taken,
//   s_axis_tready stays low; it is high whenever the output register is empty
//   or being emptied in the same cycle.
module mux_frame_deframer (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [7:0]                s_axis_tdata,   // byte_in
    input  logic                      s_axis_tlast,   // chunk_end
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // frame_type[7:0], frame_flags[15:8], channel[31:16],
    // length_field[63:32], data_byte[71:64]
    output logic [71:0]               m_axis_tdata,
    output logic [1:0]                m_axis_tuser,   // kind
    output logic                      m_axis_tlast,   // last
    input  logic                      cfg_we,
    input  logic [mfd_pkg::MAX_W-1:0] cfg_wdata       // max_payload
);

    logic [mfd_pkg::MAX_W-1:0] max_payload_reg;
    logic                      out_valid_reg;
    mfd_pkg::result_t          res;
    mfd_pkg::result_t          out_reg;
    logic                      accept;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    mfd_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_accept    (accept),
        .in_byte      (s_axis_tdata),
        .in_chunk_end (s_axis_tlast),
        .max_payload  (max_payload_reg),
        .res          (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_reg <= mfd_pkg::MAX_PAYLOAD_RST;
        end else if (cfg_we) begin
            max_payload_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= res.valid;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && res.valid) begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.data, out_reg.hdr};
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_reg.last;

`ifndef SYNTHESIS
    a_error_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == mfd_pkg::KIND_ERROR) |-> m_axis_tlast)
        else $error("error result without tlast");

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tuser == mfd_pkg::KIND_HEADER
                        || m_axis_tuser == mfd_pkg::KIND_DATA
                        || m_axis_tuser == mfd_pkg::KIND_ERROR))
        else $error("illegal result kind");

    a_data_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser != mfd_pkg::KIND_DATA)
            |-> (m_axis_tdata[71:64] == 8'd0 && m_axis_tlast))
        else $error("non-data result carries a byte or lacks tlast");

    a_no_result_on_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_axis_tvalid && !(s_axis_tvalid && s_axis_tready)) |=> !m_axis_tvalid)
        else $error("result appeared without an input transaction");
`endif

endmodule

>>> tb/sv/mfd_checker.sv
// Deframer checker: follows both channels, predicts each result and compares it.
`timescale 1ns / 1ps
module mfd_checker (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_axis_tvalid,
    input  logic                      s_axis_tready,
    input  logic [7:0]                s_axis_tdata,
    input  logic                      s_axis_tlast,
    input  logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    input  logic [71:0]               m_axis_tdata,
    input  logic [1:0]                m_axis_tuser,
    input  logic                      m_axis_tlast,
    input  logic                      cfg_we,
    input  logic [mfd_pkg::MAX_W-1:0] cfg_wdata,
    output int                        errors,
    output int                        pending,
    output int                        n_payload,
    output int                        n_empty,
    output int                        n_oversize
);

    typedef struct packed {
        mfd_pkg::kind_t kind;
        logic [7:0]     ftype;
        logic [7:0]     flags;
        logic [15:0]    chan;
        logic [31:0]    len;
        logic [7:0]     data;
        logic           last;
    } deframe_res_t;

    // predictor state
    logic [mfd_pkg::HDR_W-1:0]     hdr;
    logic [mfd_pkg::HDR_CNT_W-1:0] hdr_cnt;
    logic [mfd_pkg::LEN_W-1:0]     bytes_left;
    logic                          dropping;
    logic [mfd_pkg::MAX_W-1:0]     max_len;

    deframe_res_t expected_q[$];
    deframe_res_t want;
    deframe_res_t got;

    initial begin
        errors     = 0;
        pending    = 0;
        n_payload  = 0;
        n_empty    = 0;
        n_oversize = 0;
    end

    function automatic deframe_res_t frame_result(mfd_pkg::kind_t k, logic [7:0] d, logic l);
        deframe_res_t r;
        r.kind  = k;
        r.ftype = hdr[7:0];
        r.flags = hdr[15:8];
        r.chan  = hdr[31:16];
        r.len   = hdr[63:32];
        r.data  = d;
        r.last  = l;
        return r;
    endfunction

    task automatic deframe_byte(input logic [7:0] b, input logic cend);
        logic [mfd_pkg::LEN_W-1:0] len;
        if (dropping) begin
            // a chunk end closes the discard; that byte is dropped as well
            if (cend) dropping = 1'b0;
        end else if (hdr_cnt == mfd_pkg::HDR_FULL) begin
            bytes_left = bytes_left - 1'b1;
            expected_q = {expected_q,
                          frame_result(mfd_pkg::KIND_DATA, b, bytes_left == '0)};
            if (bytes_left == '0) begin
                hdr     = '0;
                hdr_cnt = '0;
            end
        end else begin
            hdr[8*hdr_cnt +: 8] = b;
            hdr_cnt = hdr_cnt + 1'b1;
            if (hdr_cnt == mfd_pkg::HDR_FULL) begin
                len = hdr[63:32];
                if (len > mfd_pkg::LEN_W'(max_len)) begin
                    expected_q = {expected_q,
                                  frame_result(mfd_pkg::KIND_ERROR, 8'h00, 1'b1)};
                    hdr        = '0;
                    hdr_cnt    = '0;
                    bytes_left = '0;
                    dropping   = !cend;
                end else if (len == '0) begin
                    expected_q = {expected_q,
                                  frame_result(mfd_pkg::KIND_HEADER, 8'h00, 1'b1)};
                    hdr        = '0;
                    hdr_cnt    = '0;
                    bytes_left = '0;
                end else begin
                    bytes_left = len;
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            hdr        = '0;
            hdr_cnt    = '0;
            bytes_left = '0;
            dropping   = 1'b0;
            max_len    = mfd_pkg::MAX_PAYLOAD_RST;
            expected_q.delete();
        end else begin
            // the result taken at this edge was caused by an earlier byte
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[15:8],
                        m_axis_tdata[31:16], m_axis_tdata[63:32], m_axis_tdata[71:64],
                        m_axis_tlast};
                case (m_axis_tuser)
                    mfd_pkg::KIND_DATA:   n_payload++;
                    mfd_pkg::KIND_HEADER: n_empty++;
                    default:              n_oversize++;
                endcase
                if (expected_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected result kind %0d tdata %h last %b",
                                 $time, got.kind, m_axis_tdata, got.last);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("%0t: mismatch (expected / actual)", $time);
                            $display("  kind %0d / %0d  type %h / %h  flags %h / %h",
                                     want.kind, got.kind, want.ftype, got.ftype,
                                     want.flags, got.flags);
                            $display("  channel %h / %h  length %h / %h",
                                     want.chan, got.chan, want.len, got.len);
                            $display("  data %h / %h  last %b / %b",
                                     want.data, got.data, want.last, got.last);
                        end
                    end
                end
            end
            if (cfg_we) max_len = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready) deframe_byte(s_axis_tdata, s_axis_tlast);
        end
        pending = expected_q.size();
    end

endmodule

>>> tb/sv/tb_mux_frame_deframer.sv
// Testbench top for the frame deframer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_mux_frame_deframer;

    logic                      aclk          = 1'b0;
    logic                      aresetn       = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [7:0]                s_axis_tdata  = '0;
    logic                      s_axis_tlast  = 1'b0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [71:0]               m_axis_tdata;
    logic [1:0]                m_axis_tuser;
    logic                      m_axis_tlast;
    logic                      cfg_we        = 1'b0;
    logic [mfd_pkg::MAX_W-1:0] cfg_wdata     = '0;

    int errors, pending, n_payload, n_empty, n_oversize;

    logic [mfd_pkg::MAX_W-1:0] cur_max = mfd_pkg::MAX_PAYLOAD_RST;
    logic [mfd_pkg::MAX_W-1:0] phase_max [5] = '{21'd0, 21'd5, 21'd1048576, 21'd200, 21'd0};
    bit               quiet_tx = 1'b0;
    bit               quiet_rx = 1'b0;
    int               rx_stall = 0;
    int               rx_roll;
    int               bytes_sent = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    mux_frame_deframer i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    mfd_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .errors        (errors),
        .pending       (pending),
        .n_payload     (n_payload),
        .n_empty       (n_empty),
        .n_oversize    (n_oversize)
    );

    // result side back-pressure: mostly ready, short stalls, now and then a long one
    always @(posedge aclk) begin
        if (rx_stall > 0) begin
            m_axis_tready <= 1'b0;
            rx_stall--;
        end else begin
            m_axis_tready <= 1'b1;
            rx_roll = $urandom_range(0, 99);
            if (!quiet_rx && rx_roll >= 70)
                rx_stall = (rx_roll < 95) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        end
    end

    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] sparse_ends();
        logic [7:0] e;
        for (int i = 0; i < 8; i++) e[i] = ($urandom_range(0, 7) == 0);
        return e;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic cend);
        int gap;
        s_axis_tdata  <= b;
        s_axis_tlast  <= cend;
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        bytes_sent++;
        gap = pick_gap(quiet_tx);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_header(input logic [7:0] ftype, input logic [7:0] flags,
                               input logic [15:0] chan, input logic [31:0] len,
                               input logic [7:0] ends);
        logic [63:0] h;
        h = {len, chan, flags, ftype};
        for (int i = 0; i < 8; i++) send_byte(h[8*i +: 8], ends[i]);
    endtask

    // bytes swallowed by the discard after an oversize header, chunk end last
    task automatic drop_chunk();
        int n;
        n = $urandom_range(0, 6);
        repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic random_frame();
        int          r;
        logic [31:0] len;
        logic [7:0]  ends;
        int          n;
        r    = $urandom_range(0, 99);
        ends = sparse_ends();
        if (r < 10 && cur_max < 1024) begin
            // junk bytes; a small limit makes any stray length fail fast and resync
            n = $urandom_range(1, 10);
            repeat (n) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end else if (r < 28) begin
            case ($urandom_range(0, 2))
                0:       len = cur_max + 32'd1;
                1:       len = '1;
                default: len = $urandom | 32'h0020_0000;
            endcase
            if ($urandom_range(0, 2) == 0) ends[7] = 1'b1;
            send_header(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        16'($urandom_range(0, 65535)), len, ends);
            if (!ends[7]) drop_chunk();
        end else begin
            if (r < 42 || cur_max == 0)
                len = 0;
            else if (r < 50 && cur_max <= 64)
                len = 32'(cur_max);
            else
                len = $urandom_range(1, (cur_max < 24) ? cur_max : 24);
            send_header(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        16'($urandom_range(0, 65535)), len, ends);
            for (int i = 0; i < len; i++)
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end
    endtask

    // wait until every predicted result is out
    task automatic drain();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        do begin
            @(negedge aclk);
            waited++;
        end while (pending != 0 && waited < 20000);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_max(input logic [mfd_pkg::MAX_W-1:0] v);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cur_max = v;
    endtask

    initial begin
        int phase_start;
        phase_max[4] = mfd_pkg::MAX_W'($urandom_range(1, 1048576));
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty frame with all-ones type, flags and channel, chunk end inside the header
        send_header(8'hFF, 8'hFF, 16'hFFFF, 32'h0, 8'b0000_0100);
        // oversize on a chunk's last byte: no discard afterwards
        send_header(8'h00, 8'h00, 16'h0000, 32'hFFFF_FFFF, 8'b1000_0000);
        // one past the limit, then a discard ended by a chunk end
        send_header(8'h5A, 8'hA5, 16'h1234, 32'd65537, 8'h00);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b1);

        for (int p = 0; p < 6; p++) begin
            if (p > 0) begin
                drain();
                write_max(phase_max[p-1]);
            end
            quiet_tx = ($urandom_range(0, 3) == 0);
            quiet_rx = ($urandom_range(0, 3) == 0);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < 80) random_frame();
        end
        drain();

        $display("Summary: %0d input bytes over six max_payload settings (0 up to 1048576)",
                 bytes_sent);
        $display("Summary: checked %0d payload, %0d empty-frame and %0d oversize results",
                 n_payload, n_empty, n_oversize);
        if (errors == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches, %0d results still outstanding", errors, pending);
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout: traffic stopped before the run completed");
        $display("Verification failed");
        $finish;
    end

endmodule
